// ===== src/spq_pkg.sv =====
package spq_pkg;

   // Queue depth and the widths that follow from it.
   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths of the stream payload.
   localparam int KEY_W    = 16;
   localparam int PRIO_W   = 8;
   localparam int FILL_W   = 5;

   // Request kind carried in req_tuser.
   typedef enum logic {
      ACT_PUSH = 1'b0,
      ACT_POP  = 1'b1
   } action_type;

   // Result kind carried in rsp_tuser.
   typedef enum logic [1:0] {
      ST_PUSHED  = 2'd0,
      ST_DROPPED = 2'd1,
      ST_POPPED  = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   // One stored queue entry.
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // Command broadcast to every cell in a cycle.
   typedef struct packed {
      logic      push_en;
      logic      pop_en;
      entry_type entry;
   } cell_ctrl_type;

endpackage

// ===== src/spq_cell.sv =====
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  logic          left_after,
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          after
);

   entry_type entry_ff;
   entry_type entry_in;

   // The new entry belongs behind this one when this slot is held and its
   // priority does not exceed the incoming one.
   assign after = occupied && (entry_ff.prio <= ctrl.entry.prio);
   assign entry = entry_ff;

   // A push keeps the entries in front of the insertion point, drops the new
   // entry into the first cell behind them and shifts the rest one place on.
   // A pop shifts every entry one place towards the front.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push_en) begin
         if (after) begin
            entry_in = entry_ff;
         end else if (left_after) begin
            entry_in = ctrl.entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.pop_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== src/sorted_priority_queue.sv =====
// Sorted priority queue of up to CAPACITY (key, priority) entries.
// The request channel (req_) carries one command per beat: req_tuser selects
// push or pop, req_tdata holds the key and priority of an entry to push.
// The response channel (rsp_) returns exactly one beat per request: rsp_tuser
// gives the outcome (pushed, dropped because full, popped, pop on empty) and
// rsp_tdata the popped key and priority (zero unless popped) and the number
// of entries held after the request.
// Entries sit in a row of cells in ascending priority order; equal priorities
// leave in arrival order. Every cell compares its own priority with the
// broadcast request and all cells shift together, so a request is answered
// in the cycle after it is accepted and one request per cycle is taken while the
// response side keeps up. The single output register sets that rate: while
// a response beat is stalled, no new request is taken.
// Synchronous reset empties the queue and drops any pending response beat;
// the cell contents are left as they are and are never read before written.
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // item_key[15:0], item_priority[23:16]
   input  logic [0:0]  req_tuser,   // action[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_key[15:0], out_priority[23:16],
                                    // fill_level[28:24], zero[31:29]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   status_type        rsp_status_ff;
   status_type        rsp_status_in;
   entry_type         rsp_entry_ff;
   entry_type         rsp_entry_in;
   logic [FILL_W-1:0] rsp_fill_ff;
   logic [FILL_W-1:0] rsp_fill_in;

   logic          req_beat;
   action_type    req_action;
   logic          full;
   logic          empty;
   cell_ctrl_type ctrl;

   entry_type cell_entry [CAPACITY];
   logic      cell_after [CAPACITY];
   logic      cell_occ   [CAPACITY];

   // Request decode and the command broadcast to the cells.
   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign req_beat    = req_tvalid && req_tready;
   assign req_action  = action_type'(req_tuser[0]);
   assign full        = (count_ff == CNT_W'(CAPACITY));
   assign empty       = (count_ff == '0);

   assign ctrl.push_en     = req_beat && (req_action == ACT_PUSH) && !full;
   assign ctrl.pop_en      = req_beat && (req_action == ACT_POP) && !empty;
   assign ctrl.entry.key   = req_tdata[15:0];
   assign ctrl.entry.prio  = req_tdata[23:16];

   // Row of cells; a cell is held when its place lies below the fill count.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_after;

      assign cell_occ[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_after = 1'b1;
      end else begin : g_inner
         assign left_entry = cell_entry[i-1];
         assign left_after = cell_after[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (cell_occ[i]),
         .left_after  (left_after),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .after       (cell_after[i])
      );
   end

   // Fill count and the response beat for an accepted request.
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_fill_in   = rsp_fill_ff;
      if (ctrl.push_en) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop_en) begin
         count_in = count_ff - 1'b1;
      end
      if (req_beat) begin
         rsp_valid_in = 1'b1;
         rsp_entry_in = '0;
         rsp_fill_in  = FILL_W'(count_in);
         if (req_action == ACT_PUSH) begin
            rsp_status_in = full ? ST_DROPPED : ST_PUSHED;
         end else if (empty) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_status_in = ST_POPPED;
            rsp_entry_in  = cell_entry[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_fill_ff, rsp_entry_ff.prio, rsp_entry_ff.key};

   // The fill count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   // An accepted push into a queue with room grows it by one.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.push_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow the queue");

   // A pending response reports the fill count that the queue now holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_fill_ff == FILL_W'(count_ff))
      else $error("reported fill level differs from the queue");

   // Held entries stay in ascending priority order.
   for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_order_chk
      assert property (@(posedge clock) disable iff (reset)
         cell_occ[j+1] |-> cell_entry[j].prio <= cell_entry[j+1].prio)
         else $error("queue entries out of priority order");
   end

endmodule
